// File: hw/rtl/apr_pkg.sv
// shared types and constants of the addressed packet receiver
package apr_pkg;

  // payload buffer depth; frames carry at most this minus two bytes
  localparam int unsigned PAYLOAD_CAPACITY = 64;
  localparam int unsigned ADDR_W = $clog2(PAYLOAD_CAPACITY);
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned CNT_W = SIZE_W + 1;
  localparam logic [7:0] MAX_SIZE = 8'(PAYLOAD_CAPACITY - 2);

  // stream data widths
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MY_ADDRESS = 3'd0,
    CFG_START_FIRST = 3'd1,
    CFG_START_SECOND = 3'd2,
    CFG_CRC_POLY = 3'd3,
    CFG_CRC_INIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_HUNT0,
    PH_HUNT1,
    PH_DST,
    PH_SRC,
    PH_SIZE,
    PH_DATA,
    PH_CRCHI,
    PH_CRCLO,
    PH_SKIP,
    PH_EMIT_RD,
    PH_EMIT_WR
  } phase_e;

  // one result item as held in the output register
  typedef struct packed {
    logic       last_of_frame;
    logic       has_payload;
    logic [7:0] payload_byte;
    logic [5:0] frame_size;
    logic [7:0] frame_destination;
    logic [7:0] frame_source;
  } result_t;

endpackage

// File: hw/rtl/apr_ram.sv
// generic single-port-write, registered-read ram
module apr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/addressed_packet_receiver.sv
// addressed packet receiver: frame hunt, address filter, crc check, payload readout
//
//   channel  | direction | handshake                   | contents
//   s_axis   | in        | s_axis_tvalid/s_axis_tready | one received byte
//   m_axis   | out       | m_axis_tvalid/m_axis_tready | header, payload byte, flag, tlast
//   cfg      | in        | cfg_we_i (no wait)          | register index and write data
//
// one received byte is taken per cycle in every framing phase.
// after a good crc the payload is read out of the buffer ram, each result in a
// ram read phase, then a load of the output register once it is free; s_axis_tready
// stays low during the readout. an empty frame gives one result.
// the output register lets the next byte be taken while the last result waits.
// reset returns to hunting; the payload ram needs no clearing pass.
module addressed_packet_receiver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // received byte stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [apr_pkg::S_TDATA_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [7:0] frame_source, [15:8] frame_destination, [21:16] frame_size,
  // [29:22] payload_byte, [31:30] zero
  output logic [apr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tuser,   // [0] has_payload
  output logic                             m_axis_tlast,   // last_of_frame
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [apr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [apr_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import apr_pkg::*;

  // one byte through the crc, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // configuration registers
  logic [7:0]  my_addr_q, start_first_q, start_second_q;
  logic [15:0] crc_poly_q, crc_init_q;

  // framing state
  phase_e            phase_q, phase_d;
  logic              for_me_q, for_me_d;
  logic [7:0]        src_q, src_d;
  logic [7:0]        dst_q, dst_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [15:0]       crc_q, crc_d;

  // output register
  logic    out_valid_q;
  result_t out_q, out_d;
  logic    out_load;

  logic              in_xfer;
  logic [7:0]        rx;
  logic [15:0]       crc_next, crc_start;
  logic [CNT_W-1:0]  cnt_inc, size_ext, skip_end;
  logic              emit_last;
  logic              ram_we;
  logic [7:0]        ram_rdata;

  assign rx = s_axis_tdata[7:0];
  assign s_axis_tready = (phase_q != PH_EMIT_RD) && (phase_q != PH_EMIT_WR);
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  assign crc_next  = crc_feed(crc_q, rx, crc_poly_q);
  assign crc_start = crc_feed(crc_init_q, rx, crc_poly_q);
  assign cnt_inc   = CNT_W'(cnt_q + 1'b1);
  assign size_ext  = {1'b0, size_q};
  assign skip_end  = CNT_W'(size_ext + 2'd2);
  assign emit_last = (size_q == '0) || (cnt_inc == size_ext);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_addr_q      <= 8'hFF;
      start_first_q  <= 8'h00;
      start_second_q <= 8'h00;
      crc_poly_q     <= 16'h1021;
      crc_init_q     <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MY_ADDRESS:   my_addr_q      <= cfg_data_i[7:0];
        CFG_START_FIRST:  start_first_q  <= cfg_data_i[7:0];
        CFG_START_SECOND: start_second_q <= cfg_data_i[7:0];
        CFG_CRC_POLY:     crc_poly_q     <= cfg_data_i;
        CFG_CRC_INIT:     crc_init_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // payload buffer: written during the data phase, read back at readout
  apr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_CAPACITY)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (rx),
    .raddr_i (cnt_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // next phase, crc and header capture
  always_comb begin
    phase_d  = phase_q;
    for_me_d = for_me_q;
    src_d    = src_q;
    dst_d    = dst_q;
    size_d   = size_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    ram_we   = 1'b0;
    out_load = 1'b0;
    case (phase_q)
      PH_HUNT0: begin
        if (in_xfer && rx == start_first_q) begin
          crc_d   = crc_start;
          phase_d = PH_HUNT1;
        end
      end
      PH_HUNT1: begin
        if (in_xfer) begin
          if (rx != start_second_q) begin
            phase_d = PH_HUNT0;
          end else begin
            crc_d   = crc_next;
            phase_d = PH_DST;
          end
        end
      end
      PH_DST: begin
        if (in_xfer) begin
          crc_d    = crc_next;
          dst_d    = rx;
          for_me_d = (rx == my_addr_q);
          phase_d  = PH_SRC;
        end
      end
      PH_SRC: begin
        if (in_xfer) begin
          crc_d   = crc_next;
          src_d   = rx;
          phase_d = PH_SIZE;
        end
      end
      PH_SIZE: begin
        if (in_xfer) begin
          if (rx > MAX_SIZE) begin
            phase_d = PH_HUNT0;
          end else begin
            crc_d  = crc_next;
            size_d = rx[SIZE_W-1:0];
            cnt_d  = '0;
            if (!for_me_q) begin
              phase_d = PH_SKIP;
            end else if (rx[SIZE_W-1:0] == '0) begin
              phase_d = PH_CRCHI;
            end else begin
              phase_d = PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (in_xfer) begin
          crc_d  = crc_next;
          ram_we = 1'b1;
          cnt_d  = cnt_inc;
          if (cnt_inc >= size_ext) begin
            phase_d = PH_CRCHI;
          end
        end
      end
      PH_CRCHI: begin
        if (in_xfer) begin
          crc_d   = crc_next;
          phase_d = PH_CRCLO;
        end
      end
      PH_CRCLO: begin
        if (in_xfer) begin
          crc_d = crc_next;
          if (crc_next == '0) begin
            cnt_d   = '0;
            phase_d = PH_EMIT_RD;
          end else begin
            phase_d = PH_HUNT0;
          end
        end
      end
      PH_SKIP: begin
        if (in_xfer) begin
          cnt_d = cnt_inc;
          if (cnt_inc >= skip_end) begin
            cnt_d   = '0;
            phase_d = PH_HUNT0;
          end
        end
      end
      PH_EMIT_RD: begin
        // ram read of the current entry is under way
        phase_d = PH_EMIT_WR;
      end
      PH_EMIT_WR: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          if (emit_last) begin
            cnt_d   = '0;
            phase_d = PH_HUNT0;
          end else begin
            cnt_d   = cnt_inc;
            phase_d = PH_EMIT_RD;
          end
        end
      end
      default: phase_d = PH_HUNT0;
    endcase
  end

  // result assembled from the held header and the ram data
  always_comb begin
    out_d.frame_source      = src_q;
    out_d.frame_destination = dst_q;
    out_d.frame_size        = size_q;
    out_d.payload_byte      = (size_q == '0) ? 8'h00 : ram_rdata;
    out_d.has_payload       = (size_q != '0);
    out_d.last_of_frame     = emit_last;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT0;
      for_me_q <= 1'b0;
      src_q    <= '0;
      dst_q    <= '0;
      size_q   <= '0;
      cnt_q    <= '0;
      crc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      for_me_q <= for_me_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      size_q   <= size_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.payload_byte, out_q.frame_size,
                          out_q.frame_destination, out_q.frame_source};
  assign m_axis_tuser  = out_q.has_payload;
  assign m_axis_tlast  = out_q.last_of_frame;

`ifndef SYNTHESIS
  // a new result only comes from the readout phase
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(phase_q == PH_EMIT_WR))
    else $error("result loaded outside readout");

  // payload writes stay inside the announced size
  a_data_in_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (cnt_q < size_ext))
    else $error("payload counter beyond frame size");

  // skip counter stays below the skip length
  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (cnt_q < skip_end))
    else $error("skip counter overrun");

  // readout never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("output register overwritten");
`endif

endmodule
